// File: hdl/rgmt_pkg.sv
// Shared types, constants and helper functions for the growth mortality test block.
package rgmt_pkg;

   localparam int NumSpeciesDef = 4;
   localparam int SlotW         = 2;
   localparam int CoefW         = 16;
   localparam int TableW        = 64;
   localparam int CsrIdxW       = 3;

   // Fixed-point constants
   localparam logic [29:0] Log2eQ28   = 30'd387270501;
   localparam logic [29:0] Ln2Q30     = 30'd744261118;
   localparam logic [31:0] OneQ30     = 32'h4000_0000;
   localparam int          FracBits   = 28;
   localparam int          HornerTerms = 8;
   localparam int          LogBits    = 16;
   localparam int          RecipShift = 35;

   // Widths of the exponent arguments
   localparam int TW1 = 35;  // first exp2: t from growth decay
   localparam int TW2 = 42;  // second exp2: Y * log2(1-p) in Q28

   typedef enum logic [CsrIdxW-1:0] {
      CSR_COEF_A = 3'd0,
      CSR_COEF_B = 3'd1,
      CSR_COEF_C = 3'd2,
      CSR_COEF_D = 3'd3,
      CSR_YEARS  = 3'd4
   } csr_index_type;

   // Slot s of a coefficient table sits in bits 16s+15..16s
   function automatic logic signed [CoefW-1:0] pick_coef(logic [TableW-1:0] tab,
                                                         logic [SlotW-1:0] slot);
      return tab[CoefW*slot +: CoefW];
   endfunction

   // ceil(2^35 / k): exact floor division by k for 32-bit dividends
   function automatic logic [35:0] recip_of(int unsigned k);
      logic [35:0] r;
      case (k)
         1:       r = 36'd34359738368;
         2:       r = 36'd17179869184;
         3:       r = 36'd11453246123;
         4:       r = 36'd8589934592;
         5:       r = 36'd6871947674;
         6:       r = 36'd5726623062;
         7:       r = 36'd4908534053;
         default: r = 36'd4294967296;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/rgmt_front.sv
// Front pipeline: coefficient select, linear terms, decay exponent and base-2 conversion.
module rgmt_front import rgmt_pkg::*; #(
   parameter int NUM_SPECIES = NumSpeciesDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [SlotW-1:0]      in_slot,
   input  logic [15:0]           in_resource,
   input  logic [15:0]           in_growth,
   input  logic [15:0]           in_random,
   input  logic [TableW-1:0]     coef_a,
   input  logic [TableW-1:0]     coef_b,
   input  logic [TableW-1:0]     coef_c,
   input  logic [TableW-1:0]     coef_d,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [TW1-1:0] out_t,
   output logic [31:0]           out_lin,
   output logic                  out_lin_pos,
   output logic [15:0]           out_random
);

   localparam int NS = 3;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   logic signed [33:0] lin_ff, kq_ff, lin_in, kq_in;
   logic [15:0]        g_ff, rnd0_ff, rnd1_ff, rnd2_ff;
   logic signed [33:0] z_ff, z_in;
   logic [31:0]        lin1_ff, lin2_ff;
   logic               pos1_ff, pos2_ff;
   logic signed [TW1-1:0] t_ff, t_in;

   // Stage handshake chain
   assign rdy[NS] = out_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         if (rdy[1]) vld_ff[1] <= vld_ff[0];
         if (rdy[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   // Stage 0: lin = d*256 + a*R, k = b*256 + c*R
   always_comb begin
      logic               slot_ok;
      logic signed [33:0] a_w, b_w, c_w, d_w, r_w;
      slot_ok = ({1'b0, in_slot} < 3'(NUM_SPECIES));
      a_w = slot_ok ? 34'(pick_coef(coef_a, in_slot)) : '0;
      b_w = slot_ok ? 34'(pick_coef(coef_b, in_slot)) : '0;
      c_w = slot_ok ? 34'(pick_coef(coef_c, in_slot)) : '0;
      d_w = slot_ok ? 34'(pick_coef(coef_d, in_slot)) : '0;
      r_w = signed'({18'b0, in_resource});
      lin_in = a_w * r_w + (d_w <<< 8);
      kq_in  = c_w * r_w + (b_w <<< 8);
   end

   // Stage 1: z = -(k*G), clamped to [-32, 16] in Q28
   always_comb begin
      logic signed [51:0] kw, gw, zw;
      kw = 52'(kq_ff);
      gw = signed'({36'b0, g_ff});
      zw = -(kw * gw);
      if (zw > 52'sd4294967296)
         z_in = 34'sd4294967296;
      else if (zw < -52'sd8589934592)
         z_in = -34'sd8589934592;
      else
         z_in = 34'(zw);
   end

   // Stage 2: t = floor(z * log2(e))
   always_comb begin
      logic signed [63:0] tp;
      tp   = 64'(z_ff) * signed'({34'b0, Log2eQ28});
      t_in = TW1'(tp >>> FracBits);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         lin_ff  <= lin_in;
         kq_ff   <= kq_in;
         g_ff    <= in_growth;
         rnd0_ff <= in_random;
      end
      if (rdy[1]) begin
         z_ff    <= z_in;
         lin1_ff <= lin_ff[31:0];
         pos1_ff <= (lin_ff > 34'sd0);
         rnd1_ff <= rnd0_ff;
      end
      if (rdy[2]) begin
         t_ff    <= t_in;
         lin2_ff <= lin1_ff;
         pos2_ff <= pos1_ff;
         rnd2_ff <= rnd1_ff;
      end
   end

   assign out_valid   = vld_ff[NS-1];
   assign out_t       = t_ff;
   assign out_lin     = lin2_ff;
   assign out_lin_pos = pos2_ff;
   assign out_random  = rnd2_ff;

endmodule

// File: hdl/rgmt_exp2.sv
// Pipelined 2^t: split into integer and fraction, then an 8-term Horner series for e^u.
module rgmt_exp2 import rgmt_pkg::*; #(
   parameter int TW = TW1,
   parameter int SW = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [TW-1:0]     in_t,
   input  logic [SW-1:0]            in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [31:0]              out_m,
   output logic signed [TW-29:0]    out_n,
   output logic [SW-1:0]            out_side
);

   localparam int NW = TW - FracBits;
   localparam int NS = 1 + 2 * HornerTerms;

   logic [NS-1:0]           vld_ff;
   logic [NS:0]             rdy;
   logic [29:0]             u_ff    [NS];
   logic [31:0]             val_ff  [NS];
   logic signed [NW-1:0]    n_ff    [NS];
   logic [SW-1:0]           side_ff [NS];

   // Stage handshake chain
   assign rdy[NS] = out_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) vld_ff[i] <= (i == 0) ? in_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // Stage 0: n = floor(t), u = frac(t) * ln2 in Q30
   always_ff @(posedge clock) begin
      logic [57:0] uprod;
      uprod = 58'(in_t[FracBits-1:0]) * 58'(Ln2Q30);
      if (rdy[0]) begin
         u_ff[0]    <= 30'(uprod >> FracBits);
         val_ff[0]  <= OneQ30;
         n_ff[0]    <= NW'(in_t >>> FracBits);
         side_ff[0] <= in_side;
      end
   end

   // Horner steps: odd stages multiply u*acc, even stages divide by k and add one
   for (genvar s = 1; s < NS; s++) begin : g_step
      localparam int K = HornerTerms - (s - 1) / 2;
      logic [31:0] val_in;
      if (s % 2 == 1) begin : g_mul
         always_comb begin
            logic [63:0] pr;
            pr     = 64'(u_ff[s-1]) * 64'(val_ff[s-1]);
            val_in = 32'(pr >> 30);
         end
      end else begin : g_div
         always_comb begin
            logic [67:0] pr;
            pr     = 68'(val_ff[s-1]) * 68'(recip_of(K));
            val_in = OneQ30 + 32'(pr >> RecipShift);
         end
      end
      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            u_ff[s]    <= u_ff[s-1];
            val_ff[s]  <= val_in;
            n_ff[s]    <= n_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_m     = val_ff[NS-1];
   assign out_n     = n_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

// File: hdl/rgmt_log2.sv
// Pipelined log2(q/65536) in Q16: leading-one normalize, then one squaring per fraction bit.
module rgmt_log2 import rgmt_pkg::*; #(
   parameter int SW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [16:0]        in_q,
   input  logic [SW-1:0]      in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [20:0] out_lq,
   output logic [SW-1:0]      out_side
);

   localparam int NS = 1 + LogBits;

   logic [NS-1:0]         vld_ff;
   logic [NS:0]           rdy;
   logic [30:0]           mant_ff [NS];
   logic [LogBits-1:0]    frac_ff [NS];
   logic signed [4:0]     ip_ff   [NS];
   logic [SW-1:0]         side_ff [NS];

   // Stage handshake chain
   assign rdy[NS] = out_ready;
   for (genvar i = 0; i < NS; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) vld_ff[i] <= (i == 0) ? in_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // Stage 0: leading one gives integer part, mantissa to [1,2) in Q30
   always_ff @(posedge clock) begin
      logic [4:0] b;
      b = '0;
      for (int i = 1; i < 17; i++) begin
         if (in_q[i]) b = 5'(i);
      end
      if (rdy[0]) begin
         mant_ff[0] <= 31'(in_q) << (5'd30 - b);
         frac_ff[0] <= '0;
         ip_ff[0]   <= signed'(b - 5'd16);
         side_ff[0] <= in_side;
      end
   end

   // One fraction bit per stage by squaring the mantissa
   for (genvar s = 1; s < NS; s++) begin : g_sq
      always_ff @(posedge clock) begin
         logic [61:0] pr;
         logic [31:0] sq;
         pr = 62'(mant_ff[s-1]) * 62'(mant_ff[s-1]);
         sq = 32'(pr >> 30);
         if (rdy[s]) begin
            mant_ff[s] <= sq[31] ? sq[31:1] : sq[30:0];
            frac_ff[s] <= {frac_ff[s-1][LogBits-2:0], sq[31]};
            ip_ff[s]   <= ip_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_lq    = signed'({ip_ff[NS-1], frac_ff[NS-1]});
   assign out_side  = side_ff[NS-1];

endmodule

// File: hdl/resource_growth_mortality_test.sv
// Top level of the resource-dependent growth mortality test pipeline.
//
// One tree per beat on the req_ channel: species slot in req_tuser, resource,
// growth and random code in req_tdata. Each beat yields exactly one rsp_ beat
// carrying the die flag and the compounded death probability (Q0.16).
// Coefficient tables and years per step must be written through the csr_ port
// only while no tree is in flight; the block itself does not enforce this.
// An accepted req_ beat passes 3 front stages, 17 for each of the two exp2
// units, 17 for the log2 unit and 4 glue stages on its way to rsp_tvalid.
// Throughput is one tree per cycle while rsp_tready is high; the Horner and
// squaring multipliers are each used once per stage.
// Reset empties the pipeline, clears the tables and sets years per step to
// one year (256). When rsp_tready is low the output register holds its beat;
// earlier stages keep filling bubbles and req_tready drops only once every
// stage up to the input is occupied. Nothing is dropped or repeated.
module resource_growth_mortality_test import rgmt_pkg::*; #(
   parameter int NUM_SPECIES = NumSpeciesDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [47:0]         req_tdata,   // resource_level, growth_rate, random_code
   input  logic [SlotW-1:0]    req_tuser,   // species_slot
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // dies, death_probability
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [TableW-1:0]   csr_wdata
);

   localparam int S1W = 49;
   localparam int S2W = 18;

   logic [TableW-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic [15:0]       years_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         coef_d_ff <= '0;
         years_ff  <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_A: coef_a_ff <= csr_wdata;
            CSR_COEF_B: coef_b_ff <= csr_wdata;
            CSR_COEF_C: coef_c_ff <= csr_wdata;
            CSR_COEF_D: coef_d_ff <= csr_wdata;
            CSR_YEARS:  years_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Front: linear terms and decay exponent
   logic                  fr_valid, fr_ready, fr_pos;
   logic signed [TW1-1:0] fr_t;
   logic [31:0]           fr_lin;
   logic [15:0]           fr_rnd;

   rgmt_front #(.NUM_SPECIES(NUM_SPECIES)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_slot(req_tuser), .in_resource(req_tdata[15:0]),
      .in_growth(req_tdata[31:16]), .in_random(req_tdata[47:32]),
      .coef_a(coef_a_ff), .coef_b(coef_b_ff), .coef_c(coef_c_ff), .coef_d(coef_d_ff),
      .out_valid(fr_valid), .out_ready(fr_ready),
      .out_t(fr_t), .out_lin(fr_lin), .out_lin_pos(fr_pos), .out_random(fr_rnd)
   );

   // exp(-k*G) as mantissa and exponent
   logic                     e1_valid, e1_ready;
   logic [31:0]              e1_m;
   logic signed [TW1-29:0]   e1_n;
   logic [S1W-1:0]           e1_side;

   rgmt_exp2 #(.TW(TW1), .SW(S1W)) u_exp_decay (
      .clock, .reset,
      .in_valid(fr_valid), .in_ready(fr_ready),
      .in_t(fr_t), .in_side({fr_rnd, fr_pos, fr_lin}),
      .out_valid(e1_valid), .out_ready(e1_ready),
      .out_m(e1_m), .out_n(e1_n), .out_side(e1_side)
   );

   // Glue stage T0: lin * m
   logic                   t0_vld_ff, t0_rdy;
   logic [62:0]            t0_prod_ff;
   logic signed [TW1-29:0] t0_n_ff;
   logic [15:0]            t0_rnd_ff;
   logic                   t0_pos_ff;

   // Glue stage T1: scale to p16, form q = 1 - p
   logic        t1_vld_ff, t1_rdy, t1_big_ff, t1_pos_ff, t1_big_in;
   logic [16:0] t1_q_ff, t1_q_in;
   logic [15:0] t1_rnd_ff;

   assign e1_ready = t0_rdy;
   assign t0_rdy   = !t0_vld_ff || t1_rdy;

   always_comb begin
      logic signed [7:0] sh;
      logic [62:0]       p;
      sh = 8'sd34 - 8'(t0_n_ff);
      p  = (sh >= 8'sd64) ? '0 : (t0_prod_ff >> sh[5:0]);
      t1_big_in = (p[62:16] != '0);
      t1_q_in   = t1_big_in ? 17'h10000 : (17'h10000 - 17'(p[15:0]));
   end

   // log2(1 - p)
   logic               lg_valid, lg_ready, lg_in_ready;
   logic signed [20:0] lg_lq;
   logic [S2W-1:0]     lg_side;

   assign t1_rdy = !t1_vld_ff || lg_in_ready;

   rgmt_log2 #(.SW(S2W)) u_log (
      .clock, .reset,
      .in_valid(t1_vld_ff), .in_ready(lg_in_ready),
      .in_q(t1_q_ff), .in_side({t1_rnd_ff, t1_pos_ff, t1_big_ff}),
      .out_valid(lg_valid), .out_ready(lg_ready),
      .out_lq(lg_lq), .out_side(lg_side)
   );

   // Glue stage T2: Y * log2(1-p) to Q28
   logic                  t2_vld_ff, t2_rdy;
   logic signed [TW2-1:0] t2_e_ff, t2_e_in;
   logic [S2W-1:0]        t2_side_ff;

   assign lg_ready = t2_rdy;

   always_comb begin
      logic signed [TW2-1:0] yw, lw;
      yw = signed'({26'b0, years_ff});
      lw = TW2'(lg_lq);
      t2_e_in = (yw * lw) <<< 4;
   end

   // exp2 of the compounded log
   logic                   e2_valid, e2_ready, e2_in_ready;
   logic [31:0]            e2_m;
   logic signed [TW2-29:0] e2_n;
   logic [S2W-1:0]         e2_side;

   assign t2_rdy = !t2_vld_ff || e2_in_ready;

   rgmt_exp2 #(.TW(TW2), .SW(S2W)) u_exp_comp (
      .clock, .reset,
      .in_valid(t2_vld_ff), .in_ready(e2_in_ready),
      .in_t(t2_e_ff), .in_side(t2_side_ff),
      .out_valid(e2_valid), .out_ready(e2_ready),
      .out_m(e2_m), .out_n(e2_n), .out_side(e2_side)
   );

   // Output stage T3: probability, saturation and die decision
   logic        t3_vld_ff, t3_rdy, t3_dies_ff, t3_dies_in;
   logic        t3_big_ff, t3_pos_ff;
   logic [15:0] t3_prob_ff, t3_prob_in;

   assign t3_rdy   = !t3_vld_ff || rsp_tready;
   assign e2_ready = t3_rdy;

   always_comb begin
      logic signed [15:0] sh2;
      logic [31:0]        w;
      logic [16:0]        pr;
      logic               big, pos;
      logic [15:0]        rnd;
      big = e2_side[0];
      pos = e2_side[1];
      rnd = e2_side[17:2];
      sh2 = 16'sd14 - 16'(e2_n);
      w   = (sh2 >= 16'sd64) ? '0 : (e2_m >> sh2[5:0]);
      if (w > 32'h10000) w = 32'h10000;
      pr  = 17'h10000 - 17'(w);
      if (!pos || years_ff == '0)
         t3_prob_in = '0;
      else if (big || pr[16])
         t3_prob_in = 16'hFFFF;
      else
         t3_prob_in = pr[15:0];
      t3_dies_in = pos && (rnd <= t3_prob_in);
   end

   // Glue stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff <= 1'b0;
         t1_vld_ff <= 1'b0;
         t2_vld_ff <= 1'b0;
         t3_vld_ff <= 1'b0;
      end else begin
         if (t0_rdy) t0_vld_ff <= e1_valid;
         if (t1_rdy) t1_vld_ff <= t0_vld_ff;
         if (t2_rdy) t2_vld_ff <= lg_valid;
         if (t3_rdy) t3_vld_ff <= e2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (t0_rdy) begin
         t0_prod_ff <= 63'(64'(e1_side[31:0]) * 64'(e1_m));
         t0_n_ff    <= e1_n;
         t0_pos_ff  <= e1_side[32];
         t0_rnd_ff  <= e1_side[48:33];
      end
      if (t1_rdy) begin
         t1_q_ff   <= t1_q_in;
         t1_big_ff <= t1_big_in;
         t1_pos_ff <= t0_pos_ff;
         t1_rnd_ff <= t0_rnd_ff;
      end
      if (t2_rdy) begin
         t2_e_ff    <= t2_e_in;
         t2_side_ff <= lg_side;
      end
      if (t3_rdy) begin
         t3_prob_ff <= t3_prob_in;
         t3_dies_ff <= t3_dies_in;
         t3_big_ff  <= e2_side[0];
         t3_pos_ff  <= e2_side[1];
      end
   end

   assign rsp_tvalid = t3_vld_ff;
   assign rsp_tdata  = {7'b0, t3_prob_ff, t3_dies_ff};

   // An empty output register means every stage upstream can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage empty");

   // Only a positive raw probability can kill a tree
   a_dies_needs_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> t3_pos_ff)
      else $error("tree dies with non-positive raw probability");

   // Raw probability at or above one saturates the output when years per step is nonzero
   a_big_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && t3_big_ff && t3_pos_ff && years_ff != '0
      |-> rsp_tdata[16:1] == 16'hFFFF && rsp_tdata[0])
      else $error("saturated probability not reported");

endmodule
